@@ hw/rtl/lexicographic_min_color_shortest_path_top_defines.svh @@
// Assertion macros for the shortest-path color block.
// Used by lexicographic_min_color_shortest_path_top; needs clk and arst_n in scope.
`ifndef LEXICOGRAPHIC_MIN_COLOR_SHORTEST_PATH_TOP_DEFINES_SVH
`define LEXICOGRAPHIC_MIN_COLOR_SHORTEST_PATH_TOP_DEFINES_SVH

// same-cycle implication
`define LMCSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LMCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lmcsp_pkg.sv @@
// Shared types and codes for the shortest-path color block.
// No dependencies.
package lmcsp_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [10:0] node_a;
		logic [10:0] node_b;
		logic [29:0] edge_color;
		logic [9:0]  step_index;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  path_length;
		logic        reachable;
		logic [29:0] step_color;
		logic        edge_overflow;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_SEED,
		S_BFS,
		S_CHK,
		S_CHK2,
		S_FRONT,
		S_P1,
		S_P2,
		S_RD,
		S_DONE
	} state_t;

	localparam logic [10:0] NODE_COUNT_RST = 11'd2;

endpackage

@@ hw/rtl/lmcsp_ram.sv @@
// Single-port-write, single-port-read synchronous RAM, registered read.
// Holds the edge list and the chosen colors; no dependencies.
module lmcsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/lmcsp_node_ram.sv @@
// Node table RAM: one write port, two registered read ports.
// Holds visited, frontier and hop distance per node; no dependencies.
module lmcsp_node_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

@@ hw/rtl/lexicographic_min_color_shortest_path_top.sv @@
// Shortest-path least-color search: top level with sequencer and pipelines.
// Depends on lmcsp_pkg, lmcsp_ram, lmcsp_node_ram and the defines header.
//
// Usage: input words (in_valid/in_ready, in_data) carry one action each.
// Load stores an edge and returns a word at once (edge_overflow set when
// the store is full). Run searches the stored graph and returns path
// length and reachable flag. Read returns the color at one step, passing
// through the S_RD and S_DONE states after acceptance. Clear empties the store and returns nothing.
// cfg_valid/cfg_ready writes node_count; write it only while idle.
// Run sequence: clear the node table, then one sweep of the stored edges
// per BFS layer until a sweep finds no new node, then two sweeps per
// path step (least color, then next frontier).
// Each sweep reads one edge per cycle through the edge RAM port.
// Reset empties the edge store and the last result; node_count becomes 2.
// One result word is held in an output register; a new input word is
// taken while idle and when that register is empty or being emptied, and
// a finished run or read waits in S_DONE while the receiver stalls.
`include "lexicographic_min_color_shortest_path_top_defines.svh"
module lexicographic_min_color_shortest_path_top
	import lmcsp_pkg::*;
#(
	parameter int MAX_NODES  = 1024,
	parameter int MAX_EDGES  = 4096,
	parameter int COLOR_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int NW  = NAW + 2;
	localparam int EW  = 2 * NAW + COLOR_BITS;
	localparam logic [NAW-1:0] LAST_NODE = NAW'(MAX_NODES - 1);

	state_t st_q, st_d;

	logic [10:0]         node_count_q;
	logic [ECW-1:0]      tot_q;
	logic [ECW-1:0]      ctr_q;
	logic [NAW-1:0]      clr_q;
	logic [NAW-1:0]      d_q;
	logic [NAW-1:0]      layer_q;
	logic [NAW-1:0]      step_q;
	logic [NAW-1:0]      found_len_q;
	logic                reach_q;
	logic                new_q;
	logic                have_q;
	logic [COLOR_BITS-1:0] best_q;
	logic [9:0]          idx_q;
	logic [29:0]         res_col_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                v_s1, v_s2;
	logic [NAW-1:0]      a_s2, b_s2;
	logic [COLOR_BITS-1:0] col_s2;

	logic                ewe;
	logic [EAW-1:0]      ewaddr, eraddr;
	logic [EW-1:0]       ewdata, erdata;
	logic                nwe;
	logic [NAW-1:0]      nwaddr, nra, nrb;
	logic [NW-1:0]       nwdata, nda, ndb;
	logic                cwe;
	logic [NAW-1:0]      cwaddr, craddr;
	logic [COLOR_BITS-1:0] crdata;

	logic acc, slot_free, sweep, issue, sweep_end;
	logic in_range, ovf;
	logic [31:0] na32, nb32, col32, g32, len32, idx32, crd32;
	logic [NAW-1:0] goal;
	logic [COLOR_BITS-1:0] colw;
	logic va, vb, fa, fb;
	logic [NAW-1:0] da, db;
	logic dir_ab, dir_ba, cand_a, cand_b, bfs_wa, bfs_wb;

	lmcsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
		.clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewdata),
		.raddr(eraddr), .rdata(erdata)
	);

	lmcsp_node_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NAW)) u_node_ram (
		.clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
		.raddr_a(nra), .raddr_b(nrb), .rdata_a(nda), .rdata_b(ndb)
	);

	lmcsp_ram #(.WIDTH(COLOR_BITS), .DEPTH(MAX_NODES), .AW(NAW)) u_color_ram (
		.clk(clk), .we(cwe), .waddr(cwaddr), .wdata(best_q),
		.raddr(craddr), .rdata(crdata)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (st_q == S_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign na32  = 32'(in_data.node_a);
	assign nb32  = 32'(in_data.node_b);
	assign col32 = 32'(in_data.edge_color);
	assign colw  = col32[COLOR_BITS-1:0];
	assign in_range = (na32 >= 32'd1) && (na32 <= MAX_NODES)
		&& (nb32 >= 32'd1) && (nb32 <= MAX_NODES);
	assign ovf = in_range && (32'(tot_q) >= MAX_EDGES);

	always_comb begin
		g32 = 32'(node_count_q);
		if (g32 < 32'd1) begin
			g32 = 32'd1;
		end else if (g32 > MAX_NODES) begin
			g32 = MAX_NODES;
		end
		g32 = g32 - 32'd1;
	end
	assign goal  = g32[NAW-1:0];
	assign len32 = 32'(found_len_q);
	assign idx32 = 32'(idx_q);
	assign crd32 = 32'(crdata);

	assign sweep     = (st_q == S_BFS) || (st_q == S_P1) || (st_q == S_P2);
	assign issue     = sweep && (ctr_q < tot_q);
	assign sweep_end = sweep && !issue && !v_s1 && !v_s2;

	assign va = nda[NAW+1];
	assign fa = nda[NAW];
	assign da = nda[NAW-1:0];
	assign vb = ndb[NAW+1];
	assign fb = ndb[NAW];
	assign db = ndb[NAW-1:0];
	assign dir_ab = va && vb && ({1'b0, da} == ({1'b0, db} + 1'b1));
	assign dir_ba = va && vb && ({1'b0, db} == ({1'b0, da} + 1'b1));
	assign cand_a = v_s2 && fa && dir_ab && (da == layer_q);
	assign cand_b = v_s2 && fb && dir_ba && (db == layer_q);
	assign bfs_wb = v_s2 && va && (da == d_q) && !vb;
	assign bfs_wa = v_s2 && vb && (db == d_q) && !va;

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					case (in_data.action)
						ACT_RUN:  st_d = S_CLR;
						ACT_READ: st_d = S_RD;
						default:  st_d = S_IDLE;
					endcase
				end
			end
			S_CLR:   if (clr_q == LAST_NODE) st_d = S_SEED;
			S_SEED:  st_d = S_BFS;
			S_BFS:   if (sweep_end && !new_q) st_d = S_CHK;
			S_CHK:   st_d = S_CHK2;
			S_CHK2: begin
				if (!va || (da == '0)) begin
					st_d = S_DONE;
				end else begin
					st_d = S_FRONT;
				end
			end
			S_FRONT: st_d = S_P1;
			S_P1:    if (sweep_end) st_d = S_P2;
			S_P2: begin
				if (sweep_end) begin
					st_d = ((step_q + 1'b1) == found_len_q) ? S_DONE : S_P1;
				end
			end
			S_RD:    st_d = S_DONE;
			S_DONE:  if (slot_free) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		ewe    = acc && (in_data.action == ACT_LOAD) && in_range && !ovf;
		ewaddr = tot_q[EAW-1:0];
		ewdata = {in_data.node_a[NAW-1:0] - 1'b1, in_data.node_b[NAW-1:0] - 1'b1, colw};
		eraddr = ctr_q[EAW-1:0];
		nra    = erdata[EW-1 -: NAW];
		nrb    = erdata[COLOR_BITS +: NAW];
		nwe    = 1'b0;
		nwaddr = '0;
		nwdata = '0;
		cwe    = 1'b0;
		cwaddr = step_q;
		craddr = NAW'(in_data.step_index);
		case (st_q)
			S_CLR: begin
				nwe    = 1'b1;
				nwaddr = clr_q;
			end
			S_SEED: begin
				nwe    = 1'b1;
				nwaddr = goal;
				nwdata = {1'b1, 1'b0, {NAW{1'b0}}};
			end
			S_BFS: begin
				nwe = bfs_wa || bfs_wb;
				nwaddr = bfs_wb ? b_s2 : a_s2;
				nwdata = {1'b1, 1'b0, d_q + 1'b1};
			end
			S_CHK: begin
				nra = '0;
			end
			S_FRONT: begin
				nwe    = 1'b1;
				nwaddr = '0;
				nwdata = {1'b1, 1'b1, found_len_q};
			end
			S_P1: begin
				cwe = sweep_end;
			end
			S_P2: begin
				nwe    = (cand_a || cand_b) && (col_s2 == best_q);
				nwaddr = cand_a ? b_s2 : a_s2;
				nwdata = cand_a ? {1'b1, 1'b1, db} : {1'b1, 1'b1, da};
			end
			default: begin
				nwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_s2   <= nra;
		b_s2   <= nrb;
		col_s2 <= erdata[COLOR_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			node_count_q <= NODE_COUNT_RST;
			tot_q        <= '0;
			ctr_q        <= '0;
			clr_q        <= '0;
			d_q          <= '0;
			layer_q      <= '0;
			step_q       <= '0;
			found_len_q  <= '0;
			reach_q      <= 1'b0;
			new_q        <= 1'b0;
			have_q       <= 1'b0;
			best_q       <= '0;
			idx_q        <= '0;
			res_col_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			v_s2 <= v_s1 && sweep;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (sweep) begin
				if (sweep_end) begin
					ctr_q <= '0;
				end else if (issue) begin
					ctr_q <= ctr_q + 1'b1;
				end
			end else begin
				ctr_q <= '0;
			end
			case (st_q)
				S_IDLE: begin
					clr_q <= '0;
					if (acc) begin
						idx_q     <= in_data.step_index;
						res_col_q <= '0;
						case (in_data.action)
							ACT_LOAD: begin
								if (ewe) begin
									tot_q <= tot_q + 1'b1;
								end
								out_valid_q <= 1'b1;
								out_q <= '{path_length: '0, reachable: 1'b0,
									step_color: '0, edge_overflow: ovf};
							end
							ACT_CLEAR: begin
								tot_q       <= '0;
								found_len_q <= '0;
								reach_q     <= 1'b0;
							end
							default: begin
								new_q <= 1'b0;
							end
						endcase
					end
				end
				S_CLR:  clr_q <= clr_q + 1'b1;
				S_SEED: begin
					d_q   <= '0;
					new_q <= 1'b0;
				end
				S_BFS: begin
					if (sweep_end) begin
						new_q <= 1'b0;
						if (new_q) begin
							d_q <= d_q + 1'b1;
						end
					end else if (bfs_wa || bfs_wb) begin
						new_q <= 1'b1;
					end
				end
				S_CHK2: begin
					reach_q     <= va;
					found_len_q <= va ? da : '0;
					layer_q     <= da;
					step_q      <= '0;
					have_q      <= 1'b0;
				end
				S_P1: begin
					if ((cand_a || cand_b) && (!have_q || (col_s2 < best_q))) begin
						best_q <= col_s2;
						have_q <= 1'b1;
					end
				end
				S_P2: begin
					if (sweep_end) begin
						step_q  <= step_q + 1'b1;
						layer_q <= layer_q - 1'b1;
						have_q  <= 1'b0;
					end
				end
				S_RD: begin
					if (idx32 < len32) begin
						res_col_q <= crd32[29:0];
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{path_length: len32[9:0], reachable: reach_q,
							step_color: res_col_q, edge_overflow: 1'b0};
					end
				end
				default: begin
					have_q <= have_q;
				end
			endcase
		end
	end

	`LMCSP_ASSERT_NOW(a_accept_idle, in_valid && in_ready, st_q == S_IDLE, "word taken while busy")
	`LMCSP_ASSERT_NOW(a_total_bound, 1'b1, 32'(tot_q) <= MAX_EDGES, "edge total over store depth")
	`LMCSP_ASSERT_NOW(a_p1_no_write, st_q == S_P1, !nwe, "node table written in color pass")
	`LMCSP_ASSERT_NEXT(a_done_emit, st_q == S_DONE && slot_free, out_valid, "result not presented")
endmodule
